>>> hdl/round_robin_thread_scheduler_assert.svh
// assertion macros shared by the scheduler modules
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRTS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

>>> hdl/rrts_pkg.sv
// shared types and codes of the round robin thread scheduler
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int DEF_MAX_THREADS = 16;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 4;
    localparam int TST_W  = 2;
    localparam int STAT_W = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    // thread states
    localparam logic [TST_W-1:0] TS_READY     = 2'd0;
    localparam logic [TST_W-1:0] TS_RUNNING   = 2'd1;
    localparam logic [TST_W-1:0] TS_SUSPENDED = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL          = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ID        = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY         = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONE_RUNNABLE = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOT_STARTED   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  thread_id;
        logic [TST_W-1:0] initial_state;
    } t_req_item;

    typedef struct packed {
        logic [ID_W-1:0]   current_id;
        logic              started;
        logic              switched;
        logic [ID_W-1:0]   new_id;
        logic [STAT_W-1:0] status;
    } t_res_item;

endpackage

`default_nettype wire

>>> hdl/rrts_tbl.sv
// thread state table: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rrts_tbl #(
    parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [$clog2(MAX_THREADS)-1:0]        i_waddr,
    input  wire logic [rrts_pkg::TST_W-1:0]            i_wdata,
    input  wire logic [$clog2(MAX_THREADS)-1:0]        i_raddr,
    output logic      [rrts_pkg::TST_W-1:0]            o_rdata
);

    logic [rrts_pkg::TST_W-1:0] r_mem [MAX_THREADS];
    logic [rrts_pkg::TST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/rrts_ctrl.sv
// command sequencer with the shared wrap-decrement and compare unit
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_thread_scheduler_assert.svh"

module rrts_ctrl #(
    parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_go,
    input  wire rrts_pkg::t_req_item                   i_item,
    input  wire logic                                  i_res_free,
    output logic                                       o_done,
    output rrts_pkg::t_res_item                        o_res,
    output logic                                       o_we,
    output logic      [$clog2(MAX_THREADS)-1:0]        o_waddr,
    output logic      [rrts_pkg::TST_W-1:0]            o_wdata,
    output logic      [$clog2(MAX_THREADS)-1:0]        o_raddr,
    input  wire logic [rrts_pkg::TST_W-1:0]            i_rdata
);

    localparam int SLOT_W = $clog2(MAX_THREADS);
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam int ID_W   = rrts_pkg::ID_W;
    localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_RES      = 8'b0000_0100,
        S_CUR      = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_DEMOTE   = 8'b0010_0000,
        S_PROMOTE  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_ctrl_state;

    t_ctrl_state                r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [SLOT_W-1:0]          r_cur, n_cur;
    logic                       r_started, n_started;
    logic [SLOT_W-1:0]          r_n, n_n;
    logic [CNT_W-1:0]           r_visits, n_visits;
    logic [rrts_pkg::TST_W-1:0] r_cur_state, n_cur_state;
    rrts_pkg::t_res_item        r_res, n_res;

    logic [SLOT_W-1:0]          w_dec;
    logic [SLOT_W-1:0]          w_newest;
    logic [SLOT_W-1:0]          w_id_slot;
    logic                       w_id_ok;
    logic                       w_runnable;

    // shared unit: step one slot toward older threads, wrapping to the newest
    assign w_newest   = SLOT_W'(r_count - CNT_W'(1));
    assign w_dec      = (r_n == '0) ? w_newest : r_n - SLOT_W'(1);
    assign w_id_ok    = CMP_W'(i_item.thread_id) < CMP_W'(r_count);
    assign w_id_slot  = SLOT_W'(i_item.thread_id);
    assign w_runnable = (i_rdata == rrts_pkg::TS_READY) || (i_rdata == rrts_pkg::TS_RUNNING);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_started   = r_started;
        n_n         = r_n;
        n_visits    = r_visits;
        n_cur_state = r_cur_state;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_cur;
        o_wdata     = rrts_pkg::TS_READY;
        o_raddr     = r_cur;

        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res.switched = 1'b0;
                n_res.new_id   = '0;
                n_res.status   = rrts_pkg::STAT_OK;
                n_state        = S_DONE;
                case (i_item.command)
                    rrts_pkg::CMD_APPEND: begin
                        if (r_count >= CNT_W'(MAX_THREADS)) begin
                            n_res.status = rrts_pkg::STAT_FULL;
                        end else begin
                            o_we         = 1'b1;
                            o_waddr      = SLOT_W'(r_count);
                            o_wdata      = i_item.initial_state;
                            n_res.new_id = ID_W'(r_count);
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                    rrts_pkg::CMD_SUSPEND: begin
                        if (!w_id_ok) begin
                            n_res.status = rrts_pkg::STAT_BAD_ID;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = w_id_slot;
                            o_wdata = rrts_pkg::TS_SUSPENDED;
                        end
                    end
                    rrts_pkg::CMD_RESUME: begin
                        if (!w_id_ok) begin
                            n_res.status = rrts_pkg::STAT_BAD_ID;
                        end else begin
                            o_raddr = w_id_slot;
                            n_state = S_RES;
                        end
                    end
                    rrts_pkg::CMD_START: begin
                        if (r_count == '0) begin
                            n_res.status = rrts_pkg::STAT_EMPTY;
                        end else begin
                            o_we      = 1'b1;
                            o_waddr   = w_newest;
                            o_wdata   = rrts_pkg::TS_RUNNING;
                            n_cur     = w_newest;
                            n_started = 1'b1;
                        end
                    end
                    rrts_pkg::CMD_TICK: begin
                        if (!r_started || r_count == '0) begin
                            n_res.status = rrts_pkg::STAT_NOT_STARTED;
                        end else begin
                            o_raddr = r_cur;
                            n_n     = r_cur;
                            n_state = S_CUR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RES: begin
                // a running thread stays running
                if (i_rdata != rrts_pkg::TS_RUNNING) begin
                    o_we    = 1'b1;
                    o_waddr = w_id_slot;
                    o_wdata = rrts_pkg::TS_READY;
                end
                n_state = S_DONE;
            end
            S_CUR: begin
                n_cur_state = i_rdata;
                o_raddr     = w_dec;
                n_n         = w_dec;
                n_visits    = CNT_W'(1);
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (w_runnable) begin
                    n_state = S_DEMOTE;
                end else if (r_visits == r_count) begin
                    n_res.status = rrts_pkg::STAT_NONE_RUNNABLE;
                    n_state      = S_DONE;
                end else begin
                    o_raddr  = w_dec;
                    n_n      = w_dec;
                    n_visits = r_visits + CNT_W'(1);
                end
            end
            S_DEMOTE: begin
                if (r_cur_state == rrts_pkg::TS_RUNNING) begin
                    o_we    = 1'b1;
                    o_waddr = r_cur;
                    o_wdata = rrts_pkg::TS_READY;
                end
                n_state = S_PROMOTE;
            end
            S_PROMOTE: begin
                // written after the demote so a self-switch ends running
                o_we           = 1'b1;
                o_waddr        = r_n;
                o_wdata        = rrts_pkg::TS_RUNNING;
                n_cur          = r_n;
                n_res.switched = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.current_id = ID_W'(n_cur);
        n_res.started    = n_started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_visits    <= n_visits;
        r_cur_state <= n_cur_state;
        r_res       <= n_res;
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    `RRTS_ASSERT_HOLDS(a_no_write_when_quiet, i_clk, i_rst_n, (r_state == S_IDLE || r_state == S_DONE), !o_we)
    `RRTS_ASSERT_HOLDS(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN), (r_visits != '0 && r_visits <= r_count))
    `RRTS_ASSERT_HOLDS(a_current_appended, i_clk, i_rst_n, r_started, (CNT_W'(r_cur) < r_count))
    `RRTS_ASSERT_NEXT(a_promote_switches, i_clk, i_rst_n, (r_state == S_PROMOTE), (r_res.switched && r_state == S_DONE))

endmodule

`default_nettype wire

>>> hdl/round_robin_thread_scheduler.sv
// top level of the round robin thread scheduler
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_thread_scheduler_assert.svh"

// Round robin thread scheduler. Keeps a table of up to MAX_THREADS thread
// slots (ready, running or suspended) and takes one request at a time:
// append, suspend, resume, start or schedule tick. Each request gives exactly
// one result with the current slot, the started flag, the switch flag, the
// slot given by an append and a status code. A resume makes one table read,
// and a schedule tick runs a scan loop that reads one slot per cycle through
// the single read port of the state table and steps the slot with one shared
// wrap-decrement unit, stopping at the first runnable thread or after every
// slot was visited. The next request is taken once the result has moved into
// the output register, even while that result still waits downstream. The
// state table has no reset; slots beyond the thread count are never read.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_req_valid,
    input  wire rrts_pkg::t_req_item  i_req_data,
    output logic                      o_req_stall,
    // result channel
    output logic                      o_res_valid,
    output rrts_pkg::t_res_item       o_res_data,
    input  wire logic                 i_res_stall
);

    localparam int SLOT_W = $clog2(MAX_THREADS);

    // request side: one request in flight, held in r_item while the sequencer runs
    logic                      r_busy;
    logic                      r_go;
    rrts_pkg::t_req_item       r_item;

    // result side output register
    logic                      r_res_valid;
    rrts_pkg::t_res_item       r_res_data;

    logic                      w_req_acc;
    logic                      w_res_free;
    logic                      w_done;
    logic                      w_hand;
    rrts_pkg::t_res_item       w_res;

    // table port wiring
    logic                      w_we;
    logic [SLOT_W-1:0]         w_waddr;
    logic [rrts_pkg::TST_W-1:0] w_wdata;
    logic [SLOT_W-1:0]         w_raddr;
    logic [rrts_pkg::TST_W-1:0] w_rdata;

    assign o_req_stall = r_busy;
    assign w_req_acc   = i_req_valid && !r_busy;

    // output slot is free when empty or being taken this cycle
    assign w_res_free  = !r_res_valid || !i_res_stall;
    assign w_hand      = w_done && w_res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_go        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_go <= w_req_acc;
            if (w_req_acc) begin
                r_busy <= 1'b1;
            end else if (w_hand) begin
                r_busy <= 1'b0;
            end
            if (w_hand) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_item <= i_req_data;
        end
        if (w_hand) begin
            r_res_data <= w_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;

    // sequencer and shared slot-step unit
    rrts_ctrl #(
        .MAX_THREADS (MAX_THREADS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_go),
        .i_item     (r_item),
        .i_res_free (w_res_free),
        .o_done     (w_done),
        .o_res      (w_res),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    // thread state table
    rrts_tbl #(
        .MAX_THREADS (MAX_THREADS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `RRTS_ASSERT_HOLDS(a_hand_only_busy, i_clk, i_rst_n, w_hand, r_busy)
    `RRTS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_req_acc, (r_busy && r_go))

endmodule

`default_nettype wire
